FILE: rtl/core/nfaa_pkg.sv
package nfaa_pkg;

    localparam int ARENA_BYTES = 4096;
    localparam int ARENA_WORDS = ARENA_BYTES / 4;
    localparam int ARENA_LIMIT = ARENA_WORDS * 4;
    localparam int AW          = $clog2(ARENA_WORDS);
    localparam int SCAN_CAP    = 2 * ARENA_WORDS + 4;
    localparam int IW          = $clog2(SCAN_CAP + 1);
    localparam int HDR_BYTES   = 4;
    localparam logic [7:0] CHK_SEED = 8'h5A;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_HDRERR = 2'd2
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] req_size;
        logic [15:0] free_offset;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] data_offset;
    } result_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_FCHK,
        S_ATOP,
        S_ACUR,
        S_ANXT,
        S_AMRG,
        S_ASPL,
        S_ATAKE
    } state_t;

    function automatic logic [31:0] mk_hdr(logic [15:0] len, logic [7:0] flag);
        logic [7:0] chk;
        chk = len[7:0] ^ len[15:8] ^ flag ^ CHK_SEED;
        return {chk, flag, len};
    endfunction

    // header at byte position pb: checksum, sane length, inside arena
    function automatic logic hdr_ok(logic [31:0] w, logic [16:0] pb);
        logic [7:0]  chk;
        logic [16:0] endb;
        chk  = w[7:0] ^ w[15:8] ^ w[23:16] ^ CHK_SEED;
        endb = pb + {1'b0, w[15:0]};
        return (chk == w[31:24]) && (w[15:0] >= 16'(HDR_BYTES)) && (w[1:0] == 2'b00)
            && (endb <= 17'(ARENA_LIMIT));
    endfunction

endpackage

FILE: rtl/core/nfaa_ram.sv
module nfaa_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/core/next_fit_arena_allocator.sv
// Free: the header is checked in S_FCHK and done follows; an offset rejected on sight
//   raises done straight from idle. Allocate walks headers through S_ATOP and S_ACUR,
//   merging a free neighbour in S_ANXT and S_AMRG, or splitting and taking in S_ASPL and S_ATAKE.
// Throughput: one word at a time; busy stays high until done, set by the single
//   port of the header memory. The receiver cannot stall: done lasts one cycle.
// Reset: the header memory is cleared one entry per cycle, all ARENA_BYTES / 4 entries,
//   with busy high; word 0 becomes one free block spanning the arena.
module next_fit_arena_allocator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  nfaa_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done,
    output nfaa_pkg::result_t result
);
    import nfaa_pkg::*;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] npos_reg, npos_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] rov_reg, rov_next;
    logic [AW-1:0] absorber_reg, absorber_next;
    logic          absorbed_reg, absorbed_next;
    logic [16:0]   need_reg, need_next;
    logic [16:0]   trav_reg, trav_next;
    logic [IW-1:0] iter_reg, iter_next;
    logic [31:0]   cur_reg, cur_next;
    logic [AW:0]   split_reg, split_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    logic [15:0]   off_reg, off_next;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   rdata;

    logic [16:0]   pos_b;
    logic [AW:0]   rd_lenw;
    logic [AW:0]   rd_end;
    logic          rd_ok;
    logic          off_bad;
    logic [AW-1:0] free_pos;

    nfaa_ram #(
        .DEPTH (ARENA_WORDS),
        .AW    (AW),
        .DW    (32)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (rdata)
    );

    assign pos_b   = 17'({pos_reg, 2'b00});
    assign rd_lenw = rdata[AW+2:2];
    assign rd_end  = {1'b0, pos_reg} + rd_lenw;
    assign rd_ok   = hdr_ok(rdata, (state_reg == S_ANXT) ? 17'({npos_reg, 2'b00}) : pos_b);
    assign off_bad = (cmd.free_offset < 16'(HDR_BYTES)) || (cmd.free_offset[1:0] != 2'b00)
                  || (17'(cmd.free_offset) >= 17'(ARENA_LIMIT));
    assign free_pos = cmd.free_offset[AW+1:2] - AW'(1);

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        pos_next      = pos_reg;
        npos_next     = npos_reg;
        start_next    = start_reg;
        rov_next      = rov_reg;
        absorber_next = absorber_reg;
        absorbed_next = absorbed_reg;
        need_next     = need_reg;
        trav_next     = trav_reg;
        iter_next     = iter_reg;
        cur_next      = cur_reg;
        split_next    = split_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        off_next      = off_reg;
        case (state_reg)
            S_CLR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(ARENA_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    off_next = 16'd0;
                    if (cmd.op == OP_FREE)
                    begin
                        pos_next = free_pos;
                        if (off_bad)
                        begin
                            status_next = ST_HDRERR;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = S_FCHK;
                        end
                    end
                    else
                    begin
                        need_next     = (17'(cmd.req_size) + 17'(HDR_BYTES + 3)) & ~17'd3;
                        pos_next      = rov_reg;
                        start_next    = rov_reg;
                        trav_next     = 17'd0;
                        iter_next     = '0;
                        absorbed_next = 1'b0;
                        state_next    = S_ATOP;
                    end
                end
            end
            S_FCHK:
            begin
                status_next = rd_ok ? ST_OK : ST_HDRERR;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_ATOP:
            begin
                if ((trav_reg < 17'(ARENA_LIMIT)) && (iter_reg < IW'(SCAN_CAP)))
                begin
                    iter_next  = iter_reg + IW'(1);
                    state_next = S_ACUR;
                end
                else
                begin
                    status_next = ST_NOFIT;
                    done_next   = 1'b1;
                    if (absorbed_reg)
                    begin
                        rov_next = absorber_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ACUR:
            begin
                cur_next = rdata;
                if (!rd_ok)
                begin
                    status_next = ST_HDRERR;
                    done_next   = 1'b1;
                    if (absorbed_reg)
                    begin
                        rov_next = absorber_reg;
                    end
                    state_next = S_IDLE;
                end
                else if (rdata[16])
                begin
                    trav_next  = trav_reg + 17'(rdata[15:0]);
                    pos_next   = (rd_end == (AW+1)'(ARENA_WORDS)) ? '0 : rd_end[AW-1:0];
                    state_next = S_ATOP;
                end
                else if (17'(rdata[15:0]) >= need_reg)
                begin
                    split_next = {1'b0, pos_reg} + need_reg[AW+2:2];
                    state_next = S_ASPL;
                end
                else if (rd_end == (AW+1)'(ARENA_WORDS))
                begin
                    trav_next  = trav_reg + 17'(rdata[15:0]);
                    pos_next   = '0;
                    state_next = S_ATOP;
                end
                else
                begin
                    npos_next  = rd_end[AW-1:0];
                    state_next = S_ANXT;
                end
            end
            S_ANXT:
            begin
                if (!rd_ok)
                begin
                    status_next = ST_HDRERR;
                    done_next   = 1'b1;
                    if (absorbed_reg)
                    begin
                        rov_next = absorber_reg;
                    end
                    state_next = S_IDLE;
                end
                else if (rdata[16])
                begin
                    trav_next  = trav_reg + 17'(cur_reg[15:0]);
                    pos_next   = npos_reg;
                    state_next = S_ATOP;
                end
                else
                begin
                    if (npos_reg == start_reg)
                    begin
                        absorbed_next = 1'b1;
                        absorber_next = pos_reg;
                    end
                    state_next = S_AMRG;
                end
            end
            S_AMRG:
            begin
                state_next = S_ATOP;
            end
            S_ASPL:
            begin
                state_next = S_ATAKE;
            end
            S_ATAKE:
            begin
                rov_next    = (split_reg == (AW+1)'(ARENA_WORDS)) ? '0 : split_reg[AW-1:0];
                status_next = ST_OK;
                off_next    = 16'(pos_b + 17'(HDR_BYTES));
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = pos_reg;
        mem_wdata = '0;
        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = (clr_reg == '0) ? mk_hdr(16'(ARENA_LIMIT), 8'h00) : 32'd0;
            end
            S_IDLE:
            begin
                mem_addr = free_pos;
            end
            S_FCHK:
            begin
                mem_we    = rd_ok;
                mem_addr  = pos_reg;
                mem_wdata = mk_hdr(rdata[15:0], rdata[23:16] & 8'hFE);
            end
            S_ACUR:
            begin
                mem_addr = rd_end[AW-1:0];
            end
            S_ANXT:
            begin
                mem_we    = rd_ok && !rdata[16];
                mem_addr  = pos_reg;
                mem_wdata = mk_hdr(cur_reg[15:0] + rdata[15:0], cur_reg[23:16]);
            end
            S_AMRG:
            begin
                mem_we    = 1'b1;
                mem_addr  = npos_reg;
                mem_wdata = 32'd0;
            end
            S_ASPL:
            begin
                mem_we    = 17'(cur_reg[15:0]) > need_reg;
                mem_addr  = split_reg[AW-1:0];
                mem_wdata = mk_hdr(cur_reg[15:0] - need_reg[15:0], 8'h00);
            end
            S_ATAKE:
            begin
                mem_we    = 1'b1;
                mem_addr  = pos_reg;
                mem_wdata = mk_hdr(need_reg[15:0], cur_reg[23:16] | 8'h01);
            end
            default:
            begin
                mem_addr = pos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_reg      <= '0;
            rov_reg      <= '0;
            absorbed_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            rov_reg      <= rov_next;
            absorbed_reg <= absorbed_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        npos_reg     <= npos_next;
        start_reg    <= start_next;
        absorber_reg <= absorber_next;
        need_reg     <= need_next;
        trav_reg     <= trav_next;
        iter_reg     <= iter_next;
        cur_reg      <= cur_next;
        split_reg    <= split_next;
        status_reg   <= status_next;
        off_reg      <= off_next;
    end

    assign busy               = (state_reg != S_IDLE);
    assign done               = done_reg;
    assign result.status      = status_reg;
    assign result.data_offset = off_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK) |-> (result.data_offset == 16'd0))
        else $error("failed result carries an offset");

    a_rov_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(rov_reg) < ARENA_WORDS)
        else $error("roving position beyond arena");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted word lost");

endmodule
